// ----- hw/rtl/pncd_pkg.sv -----
// Shared types and constants for the prefix-code nibble decoder.
package pncd_pkg;

    // Field widths
    localparam int BYTE_BITS    = 8;
    localparam int SYM_W        = 4;
    localparam int LEN_W        = 4;
    localparam int CODE_W       = 8;
    localparam int ENTRY_W      = 16;
    localparam int MAX_CODE_LEN = 15;
    localparam int ENTRIES_PER_WORD = 4;
    localparam int OUT_LEN_W    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 3'd4;

    localparam logic [OUT_LEN_W-1:0] OUTPUT_LENGTH_RESET = 16'd100;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // take the accepted input beat into the bit buffer
        logic step;   // decode one symbol
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic halted;    // decoding stopped until reset
        logic buf_low;   // fewer than a byte of free bits: symbols to decode
        logic out_room;  // result register can take a beat this cycle
    } dp_stat_t;

endpackage

// ----- hw/rtl/pncd_stream_if.sv -----
// Valid/ready stream interfaces for the input byte and result channels.
interface pncd_byte_if
    import pncd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface pncd_result_if
    import pncd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last_of_run;
    logic                 finished;
    logic                 no_match;

    modport source (output valid, output out_byte, output last_of_run,
                    output finished, output no_match, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input finished, input no_match, output ready);
endinterface

// ----- hw/rtl/pncd_datapath.sv -----
// Datapath: code table, bit buffer, symbol match, nibble packing, result register.
module pncd_datapath
    import pncd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int BUFFER_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [BYTE_BITS-1:0]  in_byte,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  res_ready,
    output logic                  res_valid,
    output logic [BYTE_BITS-1:0]  res_byte,
    output logic                  res_last,
    output logic                  res_finished,
    output logic                  res_no_match
);

    // Free count can pass the buffer size after an over-long code
    localparam int FREE_MAX = (BUFFER_BITS > BYTE_BITS - 1 + MAX_CODE_LEN) ?
                              BUFFER_BITS : BYTE_BITS - 1 + MAX_CODE_LEN;
    localparam int FREE_W   = $clog2(FREE_MAX + 1);

    logic [ENTRY_W-1:0]     entry_reg [TABLE_ENTRIES];
    logic [OUT_LEN_W-1:0]   out_len_reg;
    logic [BUFFER_BITS-1:0] buf_reg;
    logic [FREE_W-1:0]      free_reg;
    logic                   high_next_reg;
    logic [SYM_W-1:0]       pending_reg;
    logic [OUT_LEN_W-1:0]   written_reg;
    logic                   halted_reg;
    logic                   res_valid_reg;
    logic [BYTE_BITS-1:0]   res_byte_reg;
    logic                   res_last_reg;
    logic                   res_fin_reg;
    logic                   res_nm_reg;

    logic                   found;
    logic [LEN_W-1:0]       sel_len;
    logic [SYM_W-1:0]       sel_sym;
    logic [BUFFER_BITS-1:0] buf_shift;
    logic                   ahead_found;
    logic [LEN_W-1:0]       ahead_len;
    logic [FREE_W-1:0]      free_after;
    logic [FREE_W-1:0]      free_ahead;
    logic                   run_end;
    logic [OUT_LEN_W-1:0]   written_inc;
    logic                   fin_now;
    logic                   out_room;

    // Table entries, written from the packed configuration words
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
        localparam logic [CFG_IDX_W-1:0] WORD_IDX = CFG_IDX_W'(i / ENTRIES_PER_WORD);
        localparam int LANE = i % ENTRIES_PER_WORD;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                entry_reg[i] <= '0;
            end
            else if (cfg_we && cfg_index == WORD_IDX)
            begin
                entry_reg[i] <= cfg_data[LANE*ENTRY_W +: ENTRY_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_len_reg <= OUTPUT_LENGTH_RESET;
        end
        else if (cfg_we && cfg_index == REG_OUTPUT_LENGTH)
        begin
            out_len_reg <= cfg_data[OUT_LEN_W-1:0];
        end
    end

    // Parallel compare of the buffer head against every entry, lowest index wins
    always_comb
    begin
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] head;
        logic [MAX_CODE_LEN-1:0] mask;
        logic [MAX_CODE_LEN-1:0] code;
        found   = 1'b0;
        sel_len = '0;
        sel_sym = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            len  = entry_reg[i][LEN_W-1:0];
            mask = ~({MAX_CODE_LEN{1'b1}} << len);
            code = MAX_CODE_LEN'(entry_reg[i][ENTRY_W-1 -: CODE_W]) & mask;
            head = buf_reg[BUFFER_BITS-1 -: MAX_CODE_LEN]
                   >> (LEN_W'(MAX_CODE_LEN) - len);
            if (len != '0 && head == code)
            begin
                found   = 1'b1;
                sel_len = len;
                sel_sym = entry_reg[i][LEN_W +: SYM_W];
            end
        end
    end

    assign buf_shift = buf_reg << sel_len;

    // Same compare one symbol ahead, to tell whether a byte beat closes the run
    always_comb
    begin
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] head;
        logic [MAX_CODE_LEN-1:0] mask;
        logic [MAX_CODE_LEN-1:0] code;
        ahead_found = 1'b0;
        ahead_len   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            len  = entry_reg[i][LEN_W-1:0];
            mask = ~({MAX_CODE_LEN{1'b1}} << len);
            code = MAX_CODE_LEN'(entry_reg[i][ENTRY_W-1 -: CODE_W]) & mask;
            head = buf_shift[BUFFER_BITS-1 -: MAX_CODE_LEN]
                   >> (LEN_W'(MAX_CODE_LEN) - len);
            if (len != '0 && head == code)
            begin
                ahead_found = 1'b1;
                ahead_len   = len;
            end
        end
    end

    assign free_after  = free_reg + FREE_W'(sel_len);
    assign free_ahead  = free_after + FREE_W'(ahead_len);
    assign written_inc = written_reg + OUT_LEN_W'(1);
    assign fin_now     = (written_inc >= out_len_reg);
    assign out_room    = !res_valid_reg || res_ready;

    // Run ends here when decoding stops, the buffer needs a byte, or the next
    // symbol (a high nibble) leaves the buffer needing a byte
    assign run_end = fin_now || (free_after >= FREE_W'(BYTE_BITS))
                     || (ahead_found && (free_ahead >= FREE_W'(BYTE_BITS)));

    // Buffer, nibble packing and stop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            free_reg      <= FREE_W'(BUFFER_BITS);
            high_next_reg <= 1'b1;
            pending_reg   <= '0;
            written_reg   <= '0;
            halted_reg    <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (!halted_reg && free_reg >= FREE_W'(BYTE_BITS))
            begin
                buf_reg  <= buf_reg | (BUFFER_BITS'(in_byte)
                                       << (free_reg - FREE_W'(BYTE_BITS)));
                free_reg <= free_reg - FREE_W'(BYTE_BITS);
            end
        end
        else if (cmd.step)
        begin
            if (!found)
            begin
                halted_reg <= 1'b1;
            end
            else
            begin
                if (high_next_reg)
                begin
                    pending_reg   <= sel_sym;
                    high_next_reg <= 1'b0;
                end
                else
                begin
                    high_next_reg <= 1'b1;
                    written_reg   <= written_inc;
                    if (fin_now)
                    begin
                        halted_reg <= 1'b1;
                    end
                end
                buf_reg  <= buf_shift;
                free_reg <= free_after;
            end
        end
    end

    // Result register: a beat is built only when the slot is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.step && (!found || !high_next_reg))
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && !found)
        begin
            res_byte_reg <= '0;
            res_last_reg <= 1'b1;
            res_fin_reg  <= 1'b0;
            res_nm_reg   <= 1'b1;
        end
        else if (cmd.step && !high_next_reg)
        begin
            res_byte_reg <= {pending_reg, sel_sym};
            res_last_reg <= run_end;
            res_fin_reg  <= fin_now;
            res_nm_reg   <= 1'b0;
        end
    end

    assign stat.halted   = halted_reg;
    assign stat.buf_low  = (free_reg < FREE_W'(BYTE_BITS));
    assign stat.out_room = out_room;

    assign res_valid    = res_valid_reg;
    assign res_byte     = res_byte_reg;
    assign res_last     = res_last_reg;
    assign res_finished = res_fin_reg;
    assign res_no_match = res_nm_reg;

endmodule

// ----- hw/rtl/pncd_ctrl.sv -----
// Controller: accepts input beats and sequences one symbol decode per cycle while the result register has room.
module pncd_ctrl
    import pncd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DECODE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Commands
    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.load = in_valid && in_ready;
    assign cmd.step = (state_reg == ST_DECODE) && !stat.halted && stat.buf_low
                      && stat.out_room;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.halted || !stat.buf_low)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/prefix_code_nibble_decoder.sv -----
// Top level of the prefix-code nibble decoder.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  byte_in  | in  | valid/ready   | in_byte[7:0]
//  res_out  | out | valid/ready   | out_byte[7:0], last_of_run, finished, no_match
//  cfg      | in  | cfg_we        | cfg_index[2:0], cfg_data[63:0]
//
// An input beat is taken while the block is idle; the decode pass then decodes one
// symbol per cycle while the result register has room, until a byte of the buffer is
// free again or decoding halts, and then returns to idle. The result register is
// one deep.
// Reset is asynchronous; after it the block takes input at once.
// A stalled result beat holds the decode pass; input is taken only between passes.
module prefix_code_nibble_decoder
    import pncd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int BUFFER_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pncd_byte_if.sink             byte_in,
    pncd_result_if.source         res_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pncd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_ready (byte_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pncd_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BUFFER_BITS   (BUFFER_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_byte      (byte_in.in_byte),
        .cmd          (cmd),
        .stat         (stat),
        .res_ready    (res_out.ready),
        .res_valid    (res_out.valid),
        .res_byte     (res_out.out_byte),
        .res_last     (res_out.last_of_run),
        .res_finished (res_out.finished),
        .res_no_match (res_out.no_match)
    );

endmodule
